@@ hdl/json_string_unescape_assert.svh @@
// ---------------------------------------------------------------------------
// JSON string unescape assertion macros
// Concurrent check wrappers on i_clk, with and without reset gating.
// ---------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_ASSERT_SVH

// checked only while out of reset
`define JSU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define JSU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ hdl/jsu_pkg.sv @@
// ---------------------------------------------------------------------------
// JSON string unescape package
// Word types, decoder phases, status codes and character constants.
// ---------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
        logic [1:0] status;
    } t_out_word;

    typedef enum logic [2:0] {
        PH_WS   = 3'd0,
        PH_BODY = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX  = 3'd3,
        PH_IDLE = 3'd4
    } t_phase;

    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    localparam logic [1:0] HEX_LAST = 2'd3;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    // value of a hex digit; only meaningful when is_hex holds
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h61) begin
            d = c - 8'h57;
        end else begin
            d = c - 8'h37;
        end
        return d[3:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/jsu_decode.sv @@
// ---------------------------------------------------------------------------
// JSU decoder
// Phase state machine; decodes one accepted word per cycle into a result.
// ---------------------------------------------------------------------------
`default_nettype none

module jsu_decode (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire jsu_pkg::t_in_word  i_word,
    output logic                    o_push,
    output jsu_pkg::t_out_word      o_result
);

    jsu_pkg::t_phase r_phase, n_phase;
    logic [1:0]      r_hex_count, n_hex_count;
    logic [7:0]      r_hex_value, n_hex_value;

    logic [7:0] c;
    logic       last;
    logic       fin;
    logic [1:0] fin_status;
    logic       emit;
    logic [7:0] ch;
    logic       idle;
    logic       hexv;
    logic [3:0] hexd;

    assign c    = i_word.in_byte;
    assign last = i_word.last;
    assign hexv = jsu_pkg::is_hex(c);
    assign hexd = jsu_pkg::hex_val(c);

    // classify the byte against the current phase
    always_comb begin
        fin        = 1'b0;
        fin_status = jsu_pkg::ST_ERR;
        emit       = 1'b0;
        ch         = 8'h00;
        idle       = 1'b0;
        unique case (r_phase)
            jsu_pkg::PH_WS: begin
                if (!(c == jsu_pkg::CH_SPACE || c == jsu_pkg::CH_TAB ||
                      c == jsu_pkg::CH_LF || c == jsu_pkg::CH_CR ||
                      c == jsu_pkg::CH_QUOTE)) begin
                    fin = 1'b1;
                end
            end
            jsu_pkg::PH_BODY: begin
                if (c == jsu_pkg::CH_QUOTE) begin
                    fin        = 1'b1;
                    fin_status = jsu_pkg::ST_DONE;
                end else if (c != jsu_pkg::CH_BSLASH) begin
                    emit = 1'b1;
                    ch   = c;
                end
            end
            jsu_pkg::PH_ESC: begin
                unique case (c)
                    jsu_pkg::CH_N:      begin emit = 1'b1; ch = jsu_pkg::CH_LF; end
                    jsu_pkg::CH_T:      begin emit = 1'b1; ch = jsu_pkg::CH_TAB; end
                    jsu_pkg::CH_R:      begin emit = 1'b1; ch = jsu_pkg::CH_CR; end
                    jsu_pkg::CH_B:      begin emit = 1'b1; ch = jsu_pkg::CH_BS; end
                    jsu_pkg::CH_F:      begin emit = 1'b1; ch = jsu_pkg::CH_FF; end
                    jsu_pkg::CH_QUOTE,
                    jsu_pkg::CH_BSLASH,
                    jsu_pkg::CH_SLASH:  begin emit = 1'b1; ch = c; end
                    jsu_pkg::CH_U:      ;
                    default:            fin = 1'b1;
                endcase
            end
            jsu_pkg::PH_HEX: begin
                if (!hexv) begin
                    fin = 1'b1;
                end else if (r_hex_count == jsu_pkg::HEX_LAST) begin
                    emit = 1'b1;
                    ch   = {r_hex_value[3:0], hexd};
                end
            end
            default: idle = 1'b1;
        endcase
    end

    // result
    always_comb begin
        o_push            = 1'b0;
        o_result.has_byte = 1'b0;
        o_result.out_byte = 8'h00;
        o_result.status   = jsu_pkg::ST_RUN;
        if (i_accept && !idle) begin
            priority if (fin) begin
                o_push          = 1'b1;
                o_result.status = fin_status;
            end else if (last) begin
                o_push          = 1'b1;
                o_result.status = jsu_pkg::ST_ERR;
            end else if (emit) begin
                o_push            = 1'b1;
                o_result.has_byte = 1'b1;
                o_result.out_byte = ch;
            end
        end
    end

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_hex_count = r_hex_count;
        n_hex_value = r_hex_value;
        if (i_accept) begin
            priority if (idle) begin
                if (last) begin
                    n_phase     = jsu_pkg::PH_WS;
                    n_hex_count = 2'd0;
                    n_hex_value = 8'h00;
                end
            end else if (fin || last) begin
                n_phase     = last ? jsu_pkg::PH_WS : jsu_pkg::PH_IDLE;
                n_hex_count = 2'd0;
                n_hex_value = 8'h00;
            end else begin
                unique case (r_phase)
                    jsu_pkg::PH_WS: begin
                        if (c == jsu_pkg::CH_QUOTE) begin
                            n_phase = jsu_pkg::PH_BODY;
                        end
                    end
                    jsu_pkg::PH_BODY: begin
                        if (c == jsu_pkg::CH_BSLASH) begin
                            n_phase = jsu_pkg::PH_ESC;
                        end
                    end
                    jsu_pkg::PH_ESC: begin
                        if (c == jsu_pkg::CH_U) begin
                            n_phase     = jsu_pkg::PH_HEX;
                            n_hex_count = 2'd0;
                            n_hex_value = 8'h00;
                        end else begin
                            n_phase = jsu_pkg::PH_BODY;
                        end
                    end
                    jsu_pkg::PH_HEX: begin
                        if (r_hex_count == jsu_pkg::HEX_LAST) begin
                            n_phase     = jsu_pkg::PH_BODY;
                            n_hex_count = 2'd0;
                            n_hex_value = 8'h00;
                        end else begin
                            n_hex_count = r_hex_count + 2'd1;
                            n_hex_value = {r_hex_value[3:0], hexd};
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= jsu_pkg::PH_WS;
            r_hex_count <= 2'd0;
            r_hex_value <= 8'h00;
        end else begin
            r_phase     <= n_phase;
            r_hex_count <= n_hex_count;
            r_hex_value <= n_hex_value;
        end
    end

endmodule

`default_nettype wire

@@ hdl/jsu_skid.sv @@
// ---------------------------------------------------------------------------
// JSU output buffer
// Result register plus one skid entry; stalls input only when both are full.
// ---------------------------------------------------------------------------
`default_nettype none

module jsu_skid (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire jsu_pkg::t_out_word i_result,
    output logic                    o_full,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output jsu_pkg::t_out_word      o_out_word
);

    logic               r_out_valid, n_out_valid;
    logic               r_skid_valid, n_skid_valid;
    jsu_pkg::t_out_word r_out_word, n_out_word;
    jsu_pkg::t_out_word r_skid_word, n_skid_word;
    logic               take;

    assign take        = r_out_valid && !i_out_stall;
    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_word   = r_out_word;
        n_skid_word  = r_skid_word;
        if (take) begin
            priority if (r_skid_valid) begin
                n_out_word   = r_skid_word;
                n_skid_valid = 1'b0;
            end else if (i_push) begin
                n_out_word = i_result;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid) begin
                n_out_word  = i_result;
                n_out_valid = 1'b1;
            end else begin
                n_skid_word  = i_result;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word  <= n_out_word;
        r_skid_word <= n_skid_word;
    end

endmodule

`default_nettype wire

@@ hdl/json_string_unescape.sv @@
// ---------------------------------------------------------------------------
// JSON string unescape
// Decodes a leading JSON string literal, one byte per cycle unless stalled.
// ---------------------------------------------------------------------------
// One source byte is accepted every cycle unless the input is stalled. The
// decoder phase register is updated in the same cycle the byte is taken, so
// consecutive bytes follow back to back; each result word is registered into
// the output register, or the skid entry if that is held. A two-entry output
// buffer keeps input flowing while one result waits, and input stalls only
// when both entries are full. Whitespace, the opening quote, backslashes, the
// first three \u digits and bytes after done or error give no result word.
`default_nettype none

`include "json_string_unescape_assert.svh"

module json_string_unescape (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire jsu_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output jsu_pkg::t_out_word      o_out_word
);

    logic               accept;
    logic               push;
    jsu_pkg::t_out_word result;
    logic               full;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    jsu_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_word   (i_in_word),
        .o_push   (push),
        .o_result (result)
    );

    jsu_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_result    (result),
        .o_full      (full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    `JSU_ASSERT(a_full_has_head, o_in_stall |-> o_out_valid, "skid full with empty head")
    `JSU_ASSERT(a_byte_is_run,
        o_out_valid && o_out_word.has_byte |-> o_out_word.status == jsu_pkg::ST_RUN,
        "decoded byte with final status")
    `JSU_ASSERT(a_status_code,
        o_out_valid |-> o_out_word.status <= jsu_pkg::ST_ERR, "undefined status code")
    `JSU_ASSERT_ALWAYS(a_reset_clear,
        !$past(i_rst_n) |-> !o_out_valid && !o_in_stall, "buffer not cleared by reset")

endmodule

`default_nettype wire
